[hw/rtl/tilt_compass_quaternion_assert.svh]
// Assertion macros for the tilt compass quaternion block.
// Each macro checks one implication at the rising clock edge, with reset masking.
`ifndef TILT_COMPASS_QUATERNION_ASSERT_SVH
`define TILT_COMPASS_QUATERNION_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define TCQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tcq assertion failed");

// Next-cycle implication.
`define TCQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tcq assertion failed");

`else

`define TCQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TCQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/tcq_pkg.sv]
`timescale 1ns / 1ps

package tcq_pkg;

    // Default number of CORDIC micro-rotations.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    // Binary angles: 2^32 is one full turn.
    localparam int ANG_W = 32;
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    // Rotation datapath width (Q30 sine and cosine with headroom).
    localparam int ROT_W = 34;
    localparam logic signed [ROT_W-1:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

    // CORDIC gain in Q16, applied to the pitch numerator.
    localparam logic signed [18:0] GAIN_Q16 = 19'sd107922;

    // Configuration register indexes and reset value.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_SCALE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_SCALE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_SCALE_Z = 2'd2;
    localparam logic [15:0] SCALE_RESET = 16'd16384;

    typedef logic signed [ROT_W-1:0] t_trig;

    // Arctangent of 2^-i as a binary angle.
    function automatic logic [ANG_W-1:0] atan_ang(input int idx);
        logic [ANG_W-1:0] res;
        case (idx)
            0:       res = 32'd536870912;
            1:       res = 32'd316933406;
            2:       res = 32'd167458907;
            3:       res = 32'd85004756;
            4:       res = 32'd42667331;
            5:       res = 32'd21354465;
            6:       res = 32'd10679838;
            7:       res = 32'd5340245;
            8:       res = 32'd2670163;
            9:       res = 32'd1335087;
            10:      res = 32'd667544;
            11:      res = 32'd333772;
            12:      res = 32'd166886;
            13:      res = 32'd83443;
            14:      res = 32'd41722;
            15:      res = 32'd20861;
            16:      res = 32'd10430;
            17:      res = 32'd5215;
            18:      res = 32'd2608;
            19:      res = 32'd1304;
            20:      res = 32'd652;
            21:      res = 32'd326;
            22:      res = 32'd163;
            23:      res = 32'd81;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/tcq_vec.sv]
`timescale 1ns / 1ps

// Pipelined vectoring CORDIC: angle of (x, y) and gain-scaled magnitude.
module tcq_vec import tcq_pkg::*; #(
    parameter int W      = 34,
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SB_W   = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic [SB_W-1:0]      i_sb,
    output logic                 o_valid,
    output logic [ANG_W-1:0]     o_ang,
    output logic signed [W-1:0]  o_mag,
    output logic [SB_W-1:0]      o_sb
);

    logic                r_v    [0:STAGES];
    logic                r_zero [0:STAGES];
    logic signed [W-1:0] r_x    [0:STAGES];
    logic signed [W-1:0] r_y    [0:STAGES];
    logic [ANG_W-1:0]    r_z    [0:STAGES];
    logic [SB_W-1:0]     r_sb   [0:STAGES];

    // Entry stage: flag the zero vector and fold the left half plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_sb[0]   <= i_sb;
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= HALF_TURN;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [W-1:0] n_x;
        logic signed [W-1:0] n_y;
        logic [ANG_W-1:0]    n_z;

        always_comb begin
            if (r_y[i] >= 0) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + atan_ang(i);
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - atan_ang(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
                r_sb[i+1]   <= r_sb[i];
            end
        end
    end

    // A zero vector reports angle zero and magnitude zero.
    assign o_valid = r_v[STAGES];
    assign o_ang   = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_mag   = r_zero[STAGES] ? '0 : r_x[STAGES];
    assign o_sb    = r_sb[STAGES];

endmodule

[hw/rtl/tcq_rot.sv]
`timescale 1ns / 1ps

// Pipelined rotation CORDIC: cosine and sine of a binary angle in Q30.
module tcq_rot import tcq_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SB_W   = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [ANG_W-1:0] i_ang,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output t_trig            o_cos,
    output t_trig            o_sin,
    output logic [SB_W-1:0]  o_sb
);

    logic              r_v   [0:STAGES+1];
    logic              r_neg [0:STAGES];
    t_trig             r_x   [0:STAGES];
    t_trig             r_y   [0:STAGES];
    t_trig             r_z   [0:STAGES];
    logic [SB_W-1:0]   r_sb  [0:STAGES+1];
    t_trig             r_cos;
    t_trig             r_sin;

    t_trig n_z_dir;
    t_trig n_z_fold;

    // Angles beyond a quarter turn are turned by half a turn and negated at the end.
    assign n_z_dir  = ROT_W'($signed(i_ang));
    assign n_z_fold = ROT_W'($signed({~i_ang[ANG_W-1], i_ang[ANG_W-2:0]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= INV_GAIN_Q30;
            r_y[0]  <= '0;
            r_sb[0] <= i_sb;
            if ((n_z_dir > ONE_Q30) || (n_z_dir < -ONE_Q30)) begin
                r_z[0]   <= n_z_fold;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= n_z_dir;
                r_neg[0] <= 1'b0;
            end
        end
    end

    // One micro-rotation per stage, driving z toward zero.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        t_trig n_x;
        t_trig n_y;
        t_trig n_z;

        always_comb begin
            if (r_z[i] >= 0) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - $signed({2'b00, atan_ang(i)});
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + $signed({2'b00, atan_ang(i)});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_neg[i+1] <= r_neg[i];
                r_sb[i+1]  <= r_sb[i];
            end
        end
    end

    // Output stage applies the half-turn negation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[STAGES+1] <= 1'b0;
        end else if (i_en) begin
            r_v[STAGES+1] <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos          <= r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            r_sin          <= r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
            r_sb[STAGES+1] <= r_sb[STAGES];
        end
    end

    assign o_valid = r_v[STAGES+1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_sb    = r_sb[STAGES+1];

endmodule

[hw/rtl/tilt_compass_quaternion.sv]
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     i_valid / o_stall         i_accel_x..z, i_mag_x..z, i_mag_valid
// output    o_valid / i_stall         o_quat_w, o_quat_x, o_quat_y, o_quat_z
// config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One sample is accepted per clock while the output is not stalled; the path
// runs through the chain of roll, pitch and yaw vectoring CORDICs and the two
// rotation CORDIC rounds, plus the magnetometer and product stages.
// Reset is synchronous and active low; it clears all valid bits and loads 1.0
// into the scale registers. A stalled output freezes the whole pipeline.
`include "tilt_compass_quaternion_assert.svh"

module tilt_compass_quaternion import tcq_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    input  logic signed [15:0]   i_mag_x,
    input  logic signed [15:0]   i_mag_y,
    input  logic signed [15:0]   i_mag_z,
    input  logic                 i_mag_valid,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_quat_w,
    output logic signed [15:0]   o_quat_x,
    output logic signed [15:0]   o_quat_y,
    output logic signed [15:0]   o_quat_z,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    localparam int ROLL_W  = 34;
    localparam int PITCH_W = 38;
    localparam int YAW_W   = 40;
    localparam int PW      = 36;
    localparam int MAG_SB  = 49;
    localparam int ROLL_SB = ROLL_W + MAG_SB;
    localparam int PIT_SB  = ANG_W + MAG_SB;
    localparam int TRIG_SB = 4 * ROT_W + 1;

    // Q30 product with the low 30 bits dropped by a floor.
    function automatic logic signed [PW-1:0] mul_q30(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
        logic signed [2*PW-1:0] p;
        p = a * b;
        return p[PW+29:30];
    endfunction

    // Round Q30 to Q14 and saturate to plus or minus one.
    function automatic logic signed [15:0] to_q14(input logic signed [PW:0] v);
        logic signed [PW:0] t;
        logic signed [PW:0] r;
        t = v + (PW+1)'(32768);
        r = t >>> 16;
        if (r > (PW+1)'(16384)) begin
            return 16'sd16384;
        end else if (r < -(PW+1)'(16384)) begin
            return -16'sd16384;
        end else begin
            return r[15:0];
        end
    endfunction

    logic en;
    logic r_out_valid;

    // The whole pipeline advances unless a finished result is held back.
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Soft-iron scale registers.
    logic [15:0] r_scale_x;
    logic [15:0] r_scale_y;
    logic [15:0] r_scale_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
            r_scale_z <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAG_SCALE_X: r_scale_x <= i_cfg_data;
                CFG_MAG_SCALE_Y: r_scale_y <= i_cfg_data;
                CFG_MAG_SCALE_Z: r_scale_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Roll: atan2(ay, az) on accelerometer values scaled by 2^14.
    logic signed [ROLL_W-1:0] n_roll_x;
    logic signed [ROLL_W-1:0] n_roll_y;
    logic signed [16:0]       n_neg_ax;
    logic signed [35:0]       n_pitch_prod;
    logic signed [ROLL_W-1:0] n_pitch_y;

    assign n_roll_x     = ROLL_W'($signed({i_accel_z, 14'b0}));
    assign n_roll_y     = ROLL_W'($signed({i_accel_y, 14'b0}));
    assign n_neg_ax     = -17'(i_accel_x);
    assign n_pitch_prod = n_neg_ax * GAIN_Q16;
    assign n_pitch_y    = n_pitch_prod[35:2];

    logic                     roll_v;
    logic [ANG_W-1:0]         roll_ang;
    logic signed [ROLL_W-1:0] roll_mag;
    logic [ROLL_SB-1:0]       roll_sb;

    tcq_vec #(.W(ROLL_W), .STAGES(CORDIC_STAGES), .SB_W(ROLL_SB)) u_vec_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (n_roll_x),
        .i_y     (n_roll_y),
        .i_sb    ({n_pitch_y, i_mag_x, i_mag_y, i_mag_z, i_mag_valid}),
        .o_valid (roll_v),
        .o_ang   (roll_ang),
        .o_mag   (roll_mag),
        .o_sb    (roll_sb)
    );

    // Pitch: atan2(-ax * gain, roll magnitude).
    logic signed [ROLL_W-1:0] roll_pitch_y;
    logic [MAG_SB-1:0]        roll_mag_sb;

    assign roll_pitch_y = roll_sb[ROLL_SB-1:MAG_SB];
    assign roll_mag_sb  = roll_sb[MAG_SB-1:0];

    logic                      pitch_v;
    logic [ANG_W-1:0]          pitch_ang;
    logic signed [PITCH_W-1:0] pitch_mag;
    logic [PIT_SB-1:0]         pitch_sb;

    tcq_vec #(.W(PITCH_W), .STAGES(CORDIC_STAGES), .SB_W(PIT_SB)) u_vec_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (roll_v),
        .i_x     (PITCH_W'(roll_mag)),
        .i_y     (PITCH_W'(roll_pitch_y)),
        .i_sb    ({roll_ang, roll_mag_sb}),
        .o_valid (pitch_v),
        .o_ang   (pitch_ang),
        .o_mag   (pitch_mag),
        .o_sb    (pitch_sb)
    );

    // Sine and cosine of roll, pitch and their half angles.
    logic [ANG_W-1:0] p_roll;
    logic [ANG_W-1:0] n_half_roll;
    logic [ANG_W-1:0] n_half_pitch;

    assign p_roll       = pitch_sb[PIT_SB-1:MAG_SB];
    assign n_half_roll  = {p_roll[ANG_W-1], p_roll[ANG_W-1:1]};
    assign n_half_pitch = {pitch_ang[ANG_W-1], pitch_ang[ANG_W-1:1]};

    logic              trig_v;
    logic [MAG_SB-1:0] trig_sb;
    t_trig             cr1;
    t_trig             sr1;
    t_trig             cp1;
    t_trig             sp1;
    t_trig             cp;
    t_trig             sp;
    t_trig             cr;
    t_trig             sr;

    tcq_rot #(.STAGES(CORDIC_STAGES), .SB_W(MAG_SB)) u_rot_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pitch_v),
        .i_ang   (p_roll),
        .i_sb    (pitch_sb[MAG_SB-1:0]),
        .o_valid (trig_v),
        .o_cos   (cr1),
        .o_sin   (sr1),
        .o_sb    (trig_sb)
    );

    tcq_rot #(.STAGES(CORDIC_STAGES), .SB_W(1)) u_rot_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pitch_v),
        .i_ang   (pitch_ang),
        .i_sb    (1'b0),
        .o_valid (),
        .o_cos   (cp1),
        .o_sin   (sp1),
        .o_sb    ()
    );

    tcq_rot #(.STAGES(CORDIC_STAGES), .SB_W(1)) u_rot_hpitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pitch_v),
        .i_ang   (n_half_pitch),
        .i_sb    (1'b0),
        .o_valid (),
        .o_cos   (cp),
        .o_sin   (sp),
        .o_sb    ()
    );

    tcq_rot #(.STAGES(CORDIC_STAGES), .SB_W(1)) u_rot_hroll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pitch_v),
        .i_ang   (n_half_roll),
        .i_sb    (1'b0),
        .o_valid (),
        .o_cos   (cr),
        .o_sin   (sr),
        .o_sb    ()
    );

    // Magnetometer stage 0: soft-iron scaling and the sp1 cross terms.
    logic signed [15:0] mx_in;
    logic signed [15:0] my_in;
    logic signed [15:0] mz_in;

    assign mx_in = trig_sb[48:33];
    assign my_in = trig_sb[32:17];
    assign mz_in = trig_sb[16:1];

    logic              r_m0_v;
    logic signed [32:0] r_m0_mx;
    logic signed [32:0] r_m0_my;
    logic signed [32:0] r_m0_mz;
    logic signed [PW-1:0] r_m0_t1;
    logic signed [PW-1:0] r_m0_t2;
    t_trig r_m0_cp1;
    t_trig r_m0_cr1;
    t_trig r_m0_sr1;
    t_trig r_m0_cp;
    t_trig r_m0_sp;
    t_trig r_m0_cr;
    t_trig r_m0_sr;
    logic  r_m0_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_v <= 1'b0;
        end else if (en) begin
            r_m0_v <= trig_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m0_mx  <= 33'(mx_in) * $signed({17'b0, r_scale_x});
            r_m0_my  <= 33'(my_in) * $signed({17'b0, r_scale_y});
            r_m0_mz  <= 33'(mz_in) * $signed({17'b0, r_scale_z});
            r_m0_t1  <= mul_q30(PW'(sp1), PW'(sr1));
            r_m0_t2  <= mul_q30(PW'(sp1), PW'(cr1));
            r_m0_cp1 <= cp1;
            r_m0_cr1 <= cr1;
            r_m0_sr1 <= sr1;
            r_m0_cp  <= cp;
            r_m0_sp  <= sp;
            r_m0_cr  <= cr;
            r_m0_sr  <= sr;
            r_m0_mv  <= trig_sb[0];
        end
    end

    // Magnetometer stage 1: tilt-compensation products.
    logic                 r_m1_v;
    logic signed [PW-1:0] r_m1_a;
    logic signed [PW-1:0] r_m1_b;
    logic signed [PW-1:0] r_m1_c;
    logic signed [PW-1:0] r_m1_d;
    logic signed [PW-1:0] r_m1_e;
    t_trig r_m1_cp;
    t_trig r_m1_sp;
    t_trig r_m1_cr;
    t_trig r_m1_sr;
    logic  r_m1_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= r_m0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_a  <= mul_q30(PW'(r_m0_mx), PW'(r_m0_cp1));
            r_m1_b  <= mul_q30(PW'(r_m0_my), r_m0_t1);
            r_m1_c  <= mul_q30(PW'(r_m0_mz), r_m0_t2);
            r_m1_d  <= mul_q30(PW'(r_m0_my), PW'(r_m0_cr1));
            r_m1_e  <= mul_q30(PW'(r_m0_mz), PW'(r_m0_sr1));
            r_m1_cp <= r_m0_cp;
            r_m1_sp <= r_m0_sp;
            r_m1_cr <= r_m0_cr;
            r_m1_sr <= r_m0_sr;
            r_m1_mv <= r_m0_mv;
        end
    end

    // Magnetometer stage 2: horizontal field components, y already negated.
    logic                    r_m2_v;
    logic signed [YAW_W-1:0] r_m2_mxh;
    logic signed [YAW_W-1:0] r_m2_nmyh;
    logic [TRIG_SB-1:0]      r_m2_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_mxh  <= YAW_W'(r_m1_a) + YAW_W'(r_m1_b) + YAW_W'(r_m1_c);
            r_m2_nmyh <= YAW_W'(r_m1_e) - YAW_W'(r_m1_d);
            r_m2_sb   <= {r_m1_cp, r_m1_sp, r_m1_cr, r_m1_sr, r_m1_mv};
        end
    end

    // Yaw: atan2(-myh, mxh).
    logic                    yaw_v;
    logic [ANG_W-1:0]        yaw_ang;
    logic signed [YAW_W-1:0] yaw_mag;
    logic [TRIG_SB-1:0]      yaw_sb;

    tcq_vec #(.W(YAW_W), .STAGES(CORDIC_STAGES), .SB_W(TRIG_SB)) u_vec_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m2_v),
        .i_x     (r_m2_mxh),
        .i_y     (r_m2_nmyh),
        .i_sb    (r_m2_sb),
        .o_valid (yaw_v),
        .o_ang   (yaw_ang),
        .o_mag   (yaw_mag),
        .o_sb    (yaw_sb)
    );

    logic               hy_v;
    t_trig              cy0;
    t_trig              sy0;
    logic [TRIG_SB-1:0] hy_sb;

    tcq_rot #(.STAGES(CORDIC_STAGES), .SB_W(TRIG_SB)) u_rot_hyaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (yaw_v),
        .i_ang   ({yaw_ang[ANG_W-1], yaw_ang[ANG_W-1:1]}),
        .i_sb    (yaw_sb),
        .o_valid (hy_v),
        .o_cos   (cy0),
        .o_sin   (sy0),
        .o_sb    (hy_sb)
    );

    // Quaternion stage 1: zero yaw when the magnetometer is marked invalid.
    t_trig q_cp;
    t_trig q_sp;
    t_trig q_cr;
    t_trig q_sr;
    t_trig n_cy;
    t_trig n_sy;

    assign q_cp = hy_sb[4*ROT_W:3*ROT_W+1];
    assign q_sp = hy_sb[3*ROT_W:2*ROT_W+1];
    assign q_cr = hy_sb[2*ROT_W:ROT_W+1];
    assign q_sr = hy_sb[ROT_W:1];
    assign n_cy = hy_sb[0] ? cy0 : ONE_Q30;
    assign n_sy = hy_sb[0] ? sy0 : '0;

    logic                 r_p1_v;
    logic signed [PW-1:0] r_p1_cc;
    logic signed [PW-1:0] r_p1_ss;
    logic signed [PW-1:0] r_p1_cs;
    logic signed [PW-1:0] r_p1_sc;
    t_trig r_p1_cr;
    t_trig r_p1_sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= hy_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_cc <= mul_q30(PW'(n_cy), PW'(q_cp));
            r_p1_ss <= mul_q30(PW'(n_sy), PW'(q_sp));
            r_p1_cs <= mul_q30(PW'(n_cy), PW'(q_sp));
            r_p1_sc <= mul_q30(PW'(n_sy), PW'(q_cp));
            r_p1_cr <= q_cr;
            r_p1_sr <= q_sr;
        end
    end

    // Quaternion stage 2: the eight triple products.
    logic                 r_p2_v;
    logic signed [PW-1:0] r_p2_w1;
    logic signed [PW-1:0] r_p2_w2;
    logic signed [PW-1:0] r_p2_x1;
    logic signed [PW-1:0] r_p2_x2;
    logic signed [PW-1:0] r_p2_y1;
    logic signed [PW-1:0] r_p2_y2;
    logic signed [PW-1:0] r_p2_z1;
    logic signed [PW-1:0] r_p2_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_w1 <= mul_q30(r_p1_cc, PW'(r_p1_cr));
            r_p2_w2 <= mul_q30(r_p1_ss, PW'(r_p1_sr));
            r_p2_x1 <= mul_q30(r_p1_cc, PW'(r_p1_sr));
            r_p2_x2 <= mul_q30(r_p1_ss, PW'(r_p1_cr));
            r_p2_y1 <= mul_q30(r_p1_sc, PW'(r_p1_sr));
            r_p2_y2 <= mul_q30(r_p1_cs, PW'(r_p1_cr));
            r_p2_z1 <= mul_q30(r_p1_sc, PW'(r_p1_cr));
            r_p2_z2 <= mul_q30(r_p1_cs, PW'(r_p1_sr));
        end
    end

    // Output register: sums, rounding to Q14 and saturation.
    logic signed [15:0] r_qw;
    logic signed [15:0] r_qx;
    logic signed [15:0] r_qy;
    logic signed [15:0] r_qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qw <= to_q14((PW+1)'(r_p2_w1) + (PW+1)'(r_p2_w2));
            r_qx <= to_q14((PW+1)'(r_p2_x1) - (PW+1)'(r_p2_x2));
            r_qy <= to_q14((PW+1)'(r_p2_y1) + (PW+1)'(r_p2_y2));
            r_qz <= to_q14((PW+1)'(r_p2_z1) - (PW+1)'(r_p2_z2));
        end
    end

    assign o_valid  = r_out_valid;
    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;

    // The scalar and z components both lie within plus or minus one.
    logic quat_in_range;

    assign quat_in_range = (o_quat_w <= 16'sd16384) && (o_quat_w >= -16'sd16384) &&
                           (o_quat_z <= 16'sd16384) && (o_quat_z >= -16'sd16384);

    // An empty output register never holds back the input side.
    `TCQ_ASSERT_IMPL(a_empty_no_stall, i_clk, i_rst_n, !r_out_valid, !o_stall)
    // A finished product stage reaches the output register on the next edge.
    `TCQ_ASSERT_NEXT(a_last_stage_moves, i_clk, i_rst_n, r_p2_v && en, r_out_valid)
    // The delivered scalar and z components lie within plus or minus one.
    `TCQ_ASSERT_IMPL(a_quat_range, i_clk, i_rst_n, o_valid, quat_in_range)

endmodule
